@@ rtl/ccva_pkg.sv @@
// Shared types and constants for the cyclic constant vector ALU.
// Holds the operation codes, register indexes and the control and status
// structs passed between the top level and the serial arithmetic engine.
`timescale 1ns / 1ps

package ccva_pkg;

	// Default sizes
	localparam int DATA_WIDTH_DEF = 16;
	localparam int K_DEPTH_DEF    = 4;

	// Register field widths
	localparam int OP_W      = 3;
	localparam int COUNT_W   = 3;
	localparam int POS_W     = 2;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_K_WORD0  = 3'd2;

	// Operation codes; unused codes behave as OP_ADD
	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_RSUB = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_RDIV = 3'd5
	} op_mode_t;

	// Engine command
	typedef struct packed {
		logic     start;
		op_mode_t op;
	} ctl_t;

	// Engine status
	typedef struct packed {
		logic busy;
		logic done;
	} sts_t;

endpackage

@@ rtl/cyclic_constant_vector_alu_unit.sv @@
// Cyclic constant vector ALU: each transaction carries a signed sample X,
// combined with a constant K from a table of up to K_DEPTH configured words
// (X+K, X-K, K-X, X*K, X/K or K/X, wrapped to DATA_WIDTH bits, division
// truncating toward zero; a zero divisor gives 0 with zero_divisor set).
// The table position advances once per transaction and wraps at k_count
// (a zero count acts as 1, a count above K_DEPTH as K_DEPTH) across the
// whole stream. Every mode runs the same steps: the bit-serial engine steps
// one operand bit per cycle, then passes the sign-fix step, hands the result to
// the output register and goes back to idle before it takes the next sample.
// A finished result may wait in the output register while the next sample
// is already being worked on; if that register is still full when the engine
// finishes, the engine holds its result and the input stays stalled until the
// output drains. Depends on ccva_pkg and ccva_engine.
`timescale 1ns / 1ps

module cyclic_constant_vector_alu_unit #(
	parameter int DATA_WIDTH = ccva_pkg::DATA_WIDTH_DEF,
	parameter int K_DEPTH    = ccva_pkg::K_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [ccva_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [DATA_WIDTH-1:0]             cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [DATA_WIDTH-1:0]      sample_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [DATA_WIDTH-1:0]      result_out,
	output logic                              zero_divisor
);
	import ccva_pkg::*;

	logic [OP_W-1:0]       op_mode_q;
	logic [COUNT_W-1:0]    k_count_q;
	logic [DATA_WIDTH-1:0] k_word_q [K_DEPTH];
	logic [POS_W-1:0]      pos_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] result_q;
	logic                  zero_div_q;

	logic [COUNT_W-1:0]    count_eff;
	logic [POS_W-1:0]      idx;
	logic [COUNT_W-1:0]    idx_nxt;
	logic [POS_W-1:0]      pos_d;
	logic [DATA_WIDTH-1:0] k_sel;
	logic                  accept;
	logic                  take;
	ctl_t                  ctl;
	sts_t                  sts;
	logic [DATA_WIDTH-1:0] eng_result;
	logic                  eng_zero_div;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_ADD;
			k_count_q <= COUNT_W'(1);
			for (int i = 0; i < K_DEPTH; i++) begin
				k_word_q[i] <= '0;
			end
		end else if (cfg_write_en) begin
			if (cfg_index == REG_OP_MODE) begin
				op_mode_q <= cfg_data[OP_W-1:0];
			end
			if (cfg_index == REG_K_COUNT) begin
				k_count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < K_DEPTH; i++) begin
				if (cfg_index == CFG_IDX_W'(int'(REG_K_WORD0) + i)) begin
					k_word_q[i] <= cfg_data;
				end
			end
		end
	end

	// Effective cycle length, current index and next position
	always_comb begin
		priority if (k_count_q == '0) begin
			count_eff = COUNT_W'(1);
		end else if (k_count_q > COUNT_W'(K_DEPTH)) begin
			count_eff = COUNT_W'(K_DEPTH);
		end else begin
			count_eff = k_count_q;
		end
		idx     = ({1'b0, pos_q} < count_eff) ? pos_q : '0;
		idx_nxt = {1'b0, idx} + 1'b1;
		pos_d   = (idx_nxt >= count_eff) ? '0 : idx_nxt[POS_W-1:0];
		k_sel   = '0;
		for (int i = 0; i < K_DEPTH; i++) begin
			if (idx == POS_W'(i)) begin
				k_sel = k_word_q[i];
			end
		end
	end

	assign accept    = in_valid && !in_stall;
	assign in_stall  = sts.busy;
	assign ctl.start = accept;
	assign ctl.op    = op_mode_t'(op_mode_q);
	assign take      = sts.done && (!out_valid_q || !out_stall);

	// Table position runs across the whole stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
		end
	end

	ccva_engine #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.x_in     (sample_in),
		.k_in     (k_sel),
		.take     (take),
		.sts      (sts),
		.result   (eng_result),
		.zero_div (eng_zero_div)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q   <= eng_result;
			zero_div_q <= eng_zero_div;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_out   = result_q;
	assign zero_divisor = zero_div_q;

	// An accepted transaction keeps the input side stalled while it runs
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after a transaction was accepted");

	// A new result appears only from a finished engine run
	a_out_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(sts.done))
		else $error("output valid without a finished engine run");

	// A stalled result stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(result_out) && $stable(zero_divisor))
		else $error("stalled result changed");

endmodule

@@ rtl/ccva_engine.sv @@
// Bit-serial arithmetic engine: add/subtract one bit per cycle, shift-add
// multiply and restoring divide one operand bit per cycle, then a sign fix for divide.
// Depends on ccva_pkg.
`timescale 1ns / 1ps

module ccva_engine #(
	parameter int DATA_WIDTH = ccva_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccva_pkg::ctl_t        ctl,
	input  logic [DATA_WIDTH-1:0] x_in,
	input  logic [DATA_WIDTH-1:0] k_in,
	input  logic                  take,
	output ccva_pkg::sts_t        sts,
	output logic [DATA_WIDTH-1:0] result,
	output logic                  zero_div
);
	import ccva_pkg::*;

	localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_FIX  = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_MUL = 2'd1,
		KIND_DIV = 2'd2
	} kind_t;

	state_t                state_q;
	kind_t                 kind_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  carry_q;
	logic                  neg_q;
	logic                  zero_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] res_q;

	// Operand setup values
	kind_t                 kind_d;
	logic [DATA_WIDTH-1:0] a_d;
	logic [DATA_WIDTH-1:0] b_d;
	logic                  carry_d;
	logic [DATA_WIDTH-1:0] num;
	logic [DATA_WIDTH-1:0] den;
	logic [DATA_WIDTH-1:0] mag_num;
	logic [DATA_WIDTH-1:0] mag_den;

	// Step values
	logic                  sum_bit;
	logic                  carry_nxt;
	logic [DATA_WIDTH-1:0] prod_sum;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  q_bit;
	logic [DATA_WIDTH-1:0] res_neg;

	// Operand selection at start: divide works on magnitudes
	always_comb begin
		num     = (ctl.op == OP_RDIV) ? k_in : x_in;
		den     = (ctl.op == OP_RDIV) ? x_in : k_in;
		mag_num = num[DATA_WIDTH-1] ? DATA_WIDTH'('0 - num) : num;
		mag_den = den[DATA_WIDTH-1] ? DATA_WIDTH'('0 - den) : den;
		kind_d  = KIND_ADD;
		a_d     = x_in;
		b_d     = k_in;
		carry_d = 1'b0;
		unique case (ctl.op)
			OP_MUL: begin
				kind_d = KIND_MUL;
			end
			OP_DIV, OP_RDIV: begin
				kind_d = KIND_DIV;
				a_d    = mag_num;
				b_d    = mag_den;
			end
			OP_SUB: begin
				b_d     = ~k_in;
				carry_d = 1'b1;
			end
			OP_RSUB: begin
				a_d     = k_in;
				b_d     = ~x_in;
				carry_d = 1'b1;
			end
			default: begin
				a_d = x_in;
			end
		endcase
	end

	// One step of each kind
	always_comb begin
		sum_bit   = a_q[0] ^ b_q[0] ^ carry_q;
		carry_nxt = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));
		prod_sum  = res_q + a_q;
		trial     = {rem_q, a_q[DATA_WIDTH-1]};
		diff      = trial - {1'b0, b_q};
		q_bit     = (trial >= {1'b0, b_q});
		res_neg   = DATA_WIDTH'('0 - res_q);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_ADD;
			cnt_q   <= '0;
			carry_q <= 1'b0;
			neg_q   <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						state_q <= S_RUN;
						kind_q  <= kind_d;
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
						carry_q <= carry_d;
						neg_q   <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
						zero_q  <= (kind_d == KIND_DIV) && (den == '0);
					end
				end
				S_RUN: begin
					carry_q <= carry_nxt;
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					a_q   <= a_d;
					b_q   <= b_d;
					rem_q <= '0;
					res_q <= '0;
				end
			end
			S_RUN: begin
				unique case (kind_q)
					KIND_MUL: begin
						if (b_q[0]) begin
							res_q <= prod_sum;
						end
						a_q <= {a_q[DATA_WIDTH-2:0], 1'b0};
						b_q <= {1'b0, b_q[DATA_WIDTH-1:1]};
					end
					KIND_DIV: begin
						rem_q <= q_bit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
						res_q <= {res_q[DATA_WIDTH-2:0], q_bit};
						a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
					end
					default: begin
						res_q <= {sum_bit, res_q[DATA_WIDTH-1:1]};
						a_q   <= {1'b0, a_q[DATA_WIDTH-1:1]};
						b_q   <= {1'b0, b_q[DATA_WIDTH-1:1]};
					end
				endcase
			end
			S_FIX: begin
				if (kind_q == KIND_DIV) begin
					if (zero_q) begin
						res_q <= '0;
					end else if (neg_q) begin
						res_q <= res_neg;
					end
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign sts.busy = (state_q != S_IDLE);
	assign sts.done = (state_q == S_HOLD);
	assign result   = res_q;
	assign zero_div = zero_q;

	// A start is only taken while idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start && (state_q != S_IDLE) |=> $stable(kind_q))
		else $error("engine command changed while busy");

	// Last step leads to the sign fix
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && (cnt_q == '0) |=> (state_q == S_FIX))
		else $error("engine run did not end after the last step");

	// Zero-divisor flag only in divide modes
	a_zero_div_kind: assert property (@(posedge clk) disable iff (!arst_n)
		zero_q && sts.done |-> (kind_q == KIND_DIV))
		else $error("zero divisor flagged outside a divide");

endmodule
